// ===== src/cdpn_pkg.sv =====
// Shared constants and types for the complex dot product / norm block.
`timescale 1ns / 1ps

package cdpn_pkg;

    localparam int MODE_BITS = 2;

    // mode register codes; the upper bit alone selects norm
    localparam logic [MODE_BITS-1:0] MODE_PLAIN = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CONJ  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_NORM  = 2'd2;
    localparam int MODE_NORM_BIT = 1;

    // per-word control carried from the front end to the accumulator
    typedef struct packed {
        logic sat;
        logic norm;
        logic last;
    } item_flags_t;

endpackage

// ===== src/cdpn_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface cdpn_in_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x_re;
    logic signed [SAMPLE_BITS-1:0] x_im;
    logic signed [SAMPLE_BITS-1:0] y_re;
    logic signed [SAMPLE_BITS-1:0] y_im;
    logic                          last;

    modport source (output valid, x_re, x_im, y_re, y_im, last, input ready);
    modport sink (input valid, x_re, x_im, y_re, y_im, last, output ready);
endinterface

interface cdpn_out_if #(parameter int ACC_BITS = 48);
    logic                       valid;
    logic                       ready;
    logic signed [ACC_BITS-1:0] result_re;
    logic signed [ACC_BITS-1:0] result_im;
    logic                       saturated;

    modport source (output valid, result_re, result_im, saturated, input ready);
    modport sink (input valid, result_re, result_im, saturated, output ready);
endinterface

// ===== src/cdpn_front.sv =====
// Front end: registered complex products, then term formation and clamping.
`timescale 1ns / 1ps

module cdpn_front
    import cdpn_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [MODE_BITS-1:0]       mode,
    cdpn_in_if.sink                    in_ch,
    output logic                       push_valid,
    input  logic                       push_ready,
    output logic signed [ACC_BITS-1:0] term_re,
    output logic signed [ACC_BITS-1:0] term_im,
    output item_flags_t                flags
);

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int TW = PW + 1;
    localparam int CW = (TW > ACC_BITS) ? TW : ACC_BITS;

    logic                 valid_reg, valid_next;
    logic signed [PW-1:0] a_reg, a_next;
    logic signed [PW-1:0] b_reg, b_next;
    logic signed [PW-1:0] c_reg, c_next;
    logic signed [PW-1:0] d_reg, d_next;
    logic                 norm_reg, norm_next;
    logic                 conj_reg, conj_next;
    logic                 last_reg, last_next;

    logic                 accept;
    logic signed [TW-1:0] a_w, b_w, c_w, d_w, re_w, im_w;
    logic [ACC_BITS:0]    re_c, im_c;

    // returns {clamped, value}
    function automatic logic [ACC_BITS:0] clamp_term(input logic signed [TW-1:0] v);
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        w  = CW'(v);
        hi = CW'($signed({1'b0, {(ACC_BITS-1){1'b1}}}));
        lo = ~hi;
        if (w > hi)
        begin
            return {1'b1, hi[ACC_BITS-1:0]};
        end
        else if (w < lo)
        begin
            return {1'b1, lo[ACC_BITS-1:0]};
        end
        return {1'b0, w[ACC_BITS-1:0]};
    endfunction

    assign in_ch.ready = !valid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        norm_next  = mode[MODE_NORM_BIT];
        conj_next  = !mode[MODE_NORM_BIT] && (mode == MODE_CONJ);
        last_next  = in_ch.last;
        // norm mode squares x; otherwise x times y
        a_next     = in_ch.x_re * (norm_next ? in_ch.x_re : in_ch.y_re);
        b_next     = in_ch.x_im * (norm_next ? in_ch.x_im : in_ch.y_im);
        c_next     = in_ch.x_re * in_ch.y_im;
        d_next     = in_ch.x_im * in_ch.y_re;
        valid_next = accept ? 1'b1 : (push_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
            norm_reg <= norm_next;
            conj_reg <= conj_next;
            last_reg <= last_next;
        end
    end

    always_comb
    begin
        a_w  = TW'(a_reg);
        b_w  = TW'(b_reg);
        c_w  = TW'(c_reg);
        d_w  = TW'(d_reg);
        // plain: re = ar*br - ai*bi; conj and norm add the second product
        re_w = (!norm_reg && !conj_reg) ? (a_w - b_w) : (a_w + b_w);
        im_w = conj_reg ? (c_w - d_w) : (c_w + d_w);
        re_c = clamp_term(re_w);
        im_c = clamp_term(im_w);
    end

    assign push_valid = valid_reg;
    assign term_re    = re_c[ACC_BITS-1:0];
    assign term_im    = im_c[ACC_BITS-1:0];
    assign flags.sat  = re_c[ACC_BITS] || (!norm_reg && im_c[ACC_BITS]);
    assign flags.norm = norm_reg;
    assign flags.last = last_reg;

endmodule

// ===== src/cdpn_queue.sv =====
// Small first-in first-out queue between the front end and the accumulator.
`timescale 1ns / 1ps

module cdpn_queue #(
    parameter int WIDTH = 99,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/cdpn_back.sv =====
// Back end: saturating accumulators, bit-serial square root, result register.
`timescale 1ns / 1ps

module cdpn_back
    import cdpn_pkg::*;
#(
    parameter int ACC_BITS = 48
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  logic signed [ACC_BITS-1:0] term_re,
    input  logic signed [ACC_BITS-1:0] term_im,
    input  item_flags_t                flags,
    cdpn_out_if.source                 out_ch
);

    localparam int STEPS = (ACC_BITS + 1) / 2;
    localparam int RW    = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [2:0] {
        ST_ACCUM = 3'b001,
        ST_ROOT  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic signed [ACC_BITS-1:0] sum_re_reg, sum_re_next;
    logic signed [ACC_BITS-1:0] sum_im_reg, sum_im_next;
    logic                       ovf_reg, ovf_next;
    logic [RW-1:0]              rad_reg, rad_next;
    logic [STEPS-1:0]           rem_reg, rem_next;
    logic [STEPS-1:0]           root_reg, root_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       root_sat_reg, root_sat_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [ACC_BITS-1:0] out_re_reg, out_re_next;
    logic signed [ACC_BITS-1:0] out_im_reg, out_im_next;
    logic                       out_sat_reg, out_sat_next;

    logic              out_free, do_pop, ovf_any;
    logic [ACC_BITS:0] add_re, add_im;
    logic [STEPS+1:0]  cand, trial;

    // returns {clamped, value}
    function automatic logic [ACC_BITS:0] sat_add(input logic signed [ACC_BITS-1:0] a,
                                                  input logic signed [ACC_BITS-1:0] b);
        logic signed [ACC_BITS:0] s;
        s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(b);
        if (s[ACC_BITS] != s[ACC_BITS-1])
        begin
            return s[ACC_BITS] ? {1'b1, 1'b1, {(ACC_BITS-1){1'b0}}}
                               : {1'b1, 1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return {1'b0, s[ACC_BITS-1:0]};
    endfunction

    assign out_free = !out_valid_reg || out_ch.ready;
    // a non-norm last word writes the result register on the spot
    assign pop_ready = (state_reg == ST_ACCUM) && (!flags.last || flags.norm || out_free);
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        add_re  = sat_add(sum_re_reg, term_re);
        add_im  = sat_add(sum_im_reg, term_im);
        ovf_any = ovf_reg || flags.sat || add_re[ACC_BITS] ||
                  (!flags.norm && add_im[ACC_BITS]);
        cand    = {rem_reg, rad_reg[RW-1 -: 2]};
        trial   = {root_reg, 2'b01};

        state_next     = state_reg;
        sum_re_next    = sum_re_reg;
        sum_im_next    = sum_im_reg;
        ovf_next       = ovf_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        root_sat_next  = root_sat_reg;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            ST_ACCUM:
            begin
                if (do_pop)
                begin
                    if (!flags.last)
                    begin
                        sum_re_next = add_re[ACC_BITS-1:0];
                        if (!flags.norm)
                        begin
                            sum_im_next = add_im[ACC_BITS-1:0];
                        end
                        ovf_next = ovf_any;
                    end
                    else
                    begin
                        sum_re_next = '0;
                        sum_im_next = '0;
                        ovf_next    = 1'b0;
                        if (flags.norm)
                        begin
                            // negative sum roots to zero
                            rad_next      = add_re[ACC_BITS-1] ? '0
                                                               : RW'(add_re[ACC_BITS-1:0]);
                            rem_next      = '0;
                            root_next     = '0;
                            cnt_next      = '0;
                            root_sat_next = ovf_any;
                            state_next    = ST_ROOT;
                        end
                        else
                        begin
                            out_re_next    = add_re[ACC_BITS-1:0];
                            out_im_next    = add_im[ACC_BITS-1:0];
                            out_sat_next   = ovf_any;
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end
            ST_ROOT:
            begin
                // one result bit per cycle, two radicand bits shifted in;
                // the remainder fits STEPS bits until the final step
                if (cand >= trial)
                begin
                    rem_next  = STEPS'(cand - trial);
                    root_next = {root_reg[STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = cand[STEPS-1:0];
                    root_next = {root_reg[STEPS-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_re_next    = ACC_BITS'(root_reg);
                    out_im_next    = '0;
                    out_sat_next   = root_sat_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            sum_re_reg    <= '0;
            sum_im_reg    <= '0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_re_reg    <= sum_re_next;
            sum_im_reg    <= sum_im_next;
            ovf_reg       <= ovf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        root_sat_reg <= root_sat_next;
        out_re_reg   <= out_re_next;
        out_im_reg   <= out_im_next;
        out_sat_reg  <= out_sat_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.result_re = out_re_reg;
    assign out_ch.result_im = out_im_reg;
    assign out_ch.saturated = out_sat_reg;

endmodule

// ===== src/complex_dot_product_norm_top.sv =====
// Top level of the complex dot product / Euclidean norm accumulator.
//
// in_ch takes one word per cycle: x and y complex elements in Q1.15 and a
// last flag. out_ch gives one word per vector, on the word marked last:
// the complex sum in Q18.30 (plain or conjugated), or in norm mode the
// floor square root of the summed |x|^2, plus a sticky saturation flag.
// The user writes the mode register via cfg_we / cfg_data only while idle;
// the block does not enforce it. Throughput: one input word per cycle unless
// the root or a held result stalls it. A sum result passes the product
// register and the queue, then the accumulator writes it into the result
// register. A norm result first runs the bit-serial root and then loads
// the result register; the front end keeps filling the queue meanwhile
// and in_ch stalls once full. When out_ch stalls, the result register
// holds, the accumulator keeps taking non-last words, and the queue plus
// product register backpressure in_ch once full. Reset clears sums, flag,
// mode and all valid state.
`timescale 1ns / 1ps

module complex_dot_product_norm_top
    import cdpn_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [MODE_BITS-1:0] cfg_data,
    cdpn_in_if.sink              in_ch,
    cdpn_out_if.source           out_ch
);

    localparam int QW = 2 * ACC_BITS + $bits(item_flags_t);

    logic [MODE_BITS-1:0]       mode_reg, mode_next;
    logic                       push_valid, push_ready;
    logic                       pop_valid, pop_ready;
    logic signed [ACC_BITS-1:0] f_term_re, f_term_im;
    logic signed [ACC_BITS-1:0] b_term_re, b_term_im;
    item_flags_t                f_flags, b_flags;
    logic [QW-1:0]              push_data, pop_data;

    assign mode_next = cfg_we ? cfg_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    cdpn_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .term_re    (f_term_re),
        .term_im    (f_term_im),
        .flags      (f_flags)
    );

    assign push_data = {f_flags, f_term_im, f_term_re};

    cdpn_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign b_term_re = pop_data[ACC_BITS-1:0];
    assign b_term_im = pop_data[2*ACC_BITS-1:ACC_BITS];
    assign b_flags   = pop_data[QW-1:2*ACC_BITS];

    cdpn_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .term_re   (b_term_re),
        .term_im   (b_term_im),
        .flags     (b_flags),
        .out_ch    (out_ch)
    );

endmodule

// ===== src/cdpn_checker.sv =====
// Port-level assertions for the dot product block, bound to the top level.
`timescale 1ns / 1ps

module cdpn_checker
    import cdpn_pkg::*;
#(
    parameter int ACC_BITS = 48
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cfg_we,
    input logic [MODE_BITS-1:0]       cfg_data,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [ACC_BITS-1:0] result_re,
    input logic signed [ACC_BITS-1:0] result_im,
    input logic                       saturated
);

    logic [MODE_BITS-1:0] mode_reg;
    logic [7:0]           pending_reg, pending_next;

    // last words taken whose result has not been delivered yet
    always_comb
    begin
        pending_next = pending_reg;
        if (in_valid && in_ready && in_last)
        begin
            pending_next = pending_next + 8'd1;
        end
        if (out_valid && out_ready)
        begin
            pending_next = pending_next - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_PLAIN;
            pending_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_re) && $stable(result_im) &&
                                    $stable(saturated))
        else $error("result word changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 8'd0)
        else $error("result word without a pending last word");

    a_norm_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_reg[MODE_NORM_BIT] |-> result_im == '0 &&
                                                  !result_re[ACC_BITS-1])
        else $error("norm result has imaginary part or negative root");

endmodule

bind complex_dot_product_norm_top cdpn_checker #(
    .ACC_BITS (ACC_BITS)
) u_cdpn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .result_re (out_ch.result_re),
    .result_im (out_ch.result_im),
    .saturated (out_ch.saturated)
);

// ===== dv/tb_complex_dot_product_norm_top.sv =====
// Testbench for complex_dot_product_norm_top: directed and random vectors, inline predictor.
`timescale 1ns / 1ps

module tb_complex_dot_product_norm_top;
    import cdpn_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int ACC_BITS       = 48;
    localparam longint ACC_MAX    = (64'sd1 <<< (ACC_BITS - 1)) - 1;
    localparam longint ACC_MIN    = -ACC_MAX - 1;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1100;
    localparam int CALM_TAIL      = 200;
    localparam int LONG_WORDS     = 32;     // full-scale terms, well inside the clamp

    // mode 3 also decodes as norm (upper bit only)
    localparam logic [MODE_BITS-1:0] MODE_NORM_ALT = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef struct {
        sample_t x_re;
        sample_t x_im;
        sample_t y_re;
        sample_t y_im;
        logic    last;
    } pair_word_t;

    typedef struct {
        logic signed [ACC_BITS-1:0] re;
        logic signed [ACC_BITS-1:0] im;
        logic                       sat;
    } sum_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [MODE_BITS-1:0] cfg_data;

    cdpn_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch();
    cdpn_out_if #(.ACC_BITS(ACC_BITS)) out_ch();

    complex_dot_product_norm_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .ACC_BITS(ACC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [MODE_BITS-1:0] acc_mode;
    longint acc_re;
    longint acc_im;
    bit acc_sticky;
    bit word_clipped;
    sum_result_t pending_sums[$];

    bit idle_on;
    int hold_requests;
    int mismatch_count;
    int words_sent;
    int results_checked;
    int mode_writes;
    int quiet_cycles;

    function automatic longint add_clip(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > ACC_MAX)
        begin
            word_clipped = 1'b1;
            return ACC_MAX;
        end
        if (s < ACC_MIN)
        begin
            word_clipped = 1'b1;
            return ACC_MIN;
        end
        return s;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // fold one word into the sums; a last word queues the expected result
    function automatic void accumulate_pair(input pair_word_t w);
        longint xr;
        longint xi;
        longint yr;
        longint yi;
        longint term_re;
        longint term_im;
        sum_result_t r;
        xr = w.x_re;
        xi = w.x_im;
        yr = w.y_re;
        yi = w.y_im;
        word_clipped = 1'b0;
        if (acc_mode[MODE_NORM_BIT])
        begin
            term_re = add_clip(xr * xr, xi * xi);
            acc_re = add_clip(acc_re, term_re);
        end
        else
        begin
            if (acc_mode == MODE_CONJ)
            begin
                term_re = add_clip(xr * yr, xi * yi);
                term_im = add_clip(xr * yi, -(xi * yr));
            end
            else
            begin
                term_re = add_clip(xr * yr, -(xi * yi));
                term_im = add_clip(xr * yi, xi * yr);
            end
            acc_re = add_clip(acc_re, term_re);
            acc_im = add_clip(acc_im, term_im);
        end
        if (word_clipped)
            acc_sticky = 1'b1;
        if (w.last)
        begin
            if (acc_mode[MODE_NORM_BIT])
            begin
                // negative sum only after a mode change; root taken as 0
                r.re = (acc_re > 0) ? ACC_BITS'(floor_sqrt(acc_re)) : '0;
                r.im = '0;
            end
            else
            begin
                r.re = ACC_BITS'(acc_re);
                r.im = ACC_BITS'(acc_im);
            end
            r.sat = acc_sticky;
            pending_sums.push_back(r);
            acc_re = 0;
            acc_im = 0;
            acc_sticky = 1'b0;
        end
    endfunction

    function automatic pair_word_t make_pair(input sample_t xr, input sample_t xi,
                                             input sample_t yr, input sample_t yi,
                                             input logic last);
        pair_word_t w;
        w.x_re = xr;
        w.x_im = xi;
        w.y_re = yr;
        w.y_im = yi;
        w.last = last;
        return w;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 6))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            3: return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic pair_word_t random_pair();
        return make_pair(random_sample(), random_sample(), random_sample(), random_sample(),
                         $urandom_range(0, 4) == 0);
    endfunction

    task automatic send_pair(input pair_word_t w);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.x_re  <= w.x_re;
        in_ch.x_im  <= w.x_im;
        in_ch.y_re  <= w.y_re;
        in_ch.y_im  <= w.y_im;
        in_ch.last  <= w.last;
        in_ch.valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        accumulate_pair(w);
        words_sent++;
    endtask

    // all results in, then let any non-last words finish accumulating
    task automatic wait_for_idle();
        in_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_BITS-1:0] m);
        wait_for_idle();
        cfg_data <= m;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        acc_mode = m;
        mode_writes++;
    endtask

    task automatic check_result();
        sum_result_t want;
        if (pending_sums.size() == 0)
        begin
            $error("result word with no sum pending: re=%0d im=%0d sat=%0b",
                   out_ch.result_re, out_ch.result_im, out_ch.saturated);
            mismatch_count++;
        end
        else
        begin
            want = pending_sums.pop_front();
            if (out_ch.result_re !== want.re)
            begin
                $error("result_re: expected %0d, got %0d", want.re, out_ch.result_re);
                mismatch_count++;
            end
            if (out_ch.result_im !== want.im)
            begin
                $error("result_im: expected %0d, got %0d", want.im, out_ch.result_im);
                mismatch_count++;
            end
            if (out_ch.saturated !== want.sat)
            begin
                $error("saturated: expected %0b, got %0b", want.sat, out_ch.saturated);
                mismatch_count++;
            end
            results_checked++;
        end
    endtask

    // result side: checks every word taken, drives ready with stall bursts
    initial
    begin : result_sink
        int stall_left;
        int holds_served;
        stall_left = 0;
        holds_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                check_result();
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_we === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no word moved for %0d cycles, %0d sums still pending",
                   WATCHDOG_LIMIT, pending_sums.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_plain_from_reset();
        // mode left at its reset value
        send_pair(make_pair(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1));
        send_pair(make_pair(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
        send_pair(make_pair(S_MIN, S_MAX, S_MAX, S_MIN, 1'b0));
        send_pair(make_pair(0, -1, 1, 0, 1'b1));
        send_pair(make_pair(-1, -1, -1, -1, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 1'b1));
    endtask

    task automatic test_conjugate();
        set_mode(MODE_CONJ);
        send_pair(make_pair(S_MIN, S_MAX, S_MIN, S_MAX, 1'b0));
        send_pair(make_pair(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1));
        send_pair(make_pair(S_MIN, S_MIN, S_MIN, S_MIN, 1'b1));
    endtask

    task automatic test_norm_modes();
        set_mode(MODE_NORM);
        send_pair(make_pair(S_MIN, S_MIN, S_MAX, S_MIN, 1'b1));
        send_pair(make_pair(S_MAX, S_MIN, -1, -1, 1'b0));
        send_pair(make_pair(0, 0, 12345, -12345, 1'b1));
        set_mode(MODE_NORM_ALT);
        send_pair(make_pair(S_MIN, 0, 0, 0, 1'b1));
        send_pair(make_pair(3, 4, S_MIN, S_MAX, 1'b1));
    endtask

    task automatic test_mid_vector_switch();
        // negative real sum, then closed in norm mode: root of negative is 0
        set_mode(MODE_PLAIN);
        send_pair(make_pair(S_MAX, 0, S_MIN, S_MAX, 1'b0));
        set_mode(MODE_NORM);
        send_pair(make_pair(1, 0, 0, 0, 1'b1));
        // norm part leaves the imaginary sum alone
        send_pair(make_pair(300, -400, S_MAX, S_MIN, 1'b0));
        set_mode(MODE_CONJ);
        send_pair(make_pair(1, 2, 3, 4, 1'b1));
    endtask

    task automatic test_full_scale_vectors();
        idle_on = 1'b0;
        set_mode(MODE_NORM);
        repeat (LONG_WORDS - 1) send_pair(make_pair(S_MIN, S_MIN, 0, 0, 1'b0));
        send_pair(make_pair(S_MIN, S_MIN, 0, 0, 1'b1));
        send_pair(make_pair(1, 1, 0, 0, 1'b1));        // sticky flag must stay clear
        set_mode(MODE_PLAIN);
        repeat (LONG_WORDS - 1) send_pair(make_pair(S_MIN, S_MIN, S_MAX, S_MIN, 1'b0));
        send_pair(make_pair(S_MIN, S_MIN, S_MAX, S_MIN, 1'b1));
        send_pair(make_pair(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
        idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        int n;
        set_mode(MODE_PLAIN);
        hold_requests++;
        for (n = 0; n < 48; n++)
            send_pair(make_pair(random_sample(), random_sample(), random_sample(),
                                random_sample(), n[0]));
    endtask

    task automatic test_random_vectors();
        int sent;
        int phase_words;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            idle_on = (sent < RANDOM_WORDS - CALM_TAIL) ? ($urandom_range(0, 3) != 0) : 1'b0;
            // phases may end mid-vector, so the next mode picks it up
            set_mode(logic'($urandom_range(0, 1)) ? MODE_NORM_ALT : MODE_PLAIN);
            if ($urandom_range(0, 1) == 0)
                set_mode(MODE_BITS'($urandom_range(0, 3)));
            phase_words = $urandom_range(20, 120);
            repeat (phase_words)
            begin
                send_pair(random_pair());
                sent++;
            end
        end
    endtask

    initial
    begin
        acc_mode = MODE_PLAIN;
        acc_re = 0;
        acc_im = 0;
        acc_sticky = 1'b0;
        idle_on = 1'b1;
        hold_requests = 0;
        mismatch_count = 0;
        words_sent = 0;
        results_checked = 0;
        mode_writes = 0;
        quiet_cycles = 0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_data    <= MODE_PLAIN;
        in_ch.valid <= 1'b0;
        in_ch.x_re  <= '0;
        in_ch.x_im  <= '0;
        in_ch.y_re  <= '0;
        in_ch.y_im  <= '0;
        in_ch.last  <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_from_reset();
        test_conjugate();
        test_norm_modes();
        test_mid_vector_switch();
        test_full_scale_vectors();
        test_output_backpressure();
        test_random_vectors();

        wait_for_idle();
        $display("%0d pair words sent, %0d results checked, %0d mode writes",
                 words_sent, results_checked, mode_writes);
        $display("plain, conjugate and norm sums, mid-vector mode changes, full-scale runs");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
